>>> sv/knap_pkg.sv
// shared constants, codes and types of the knapsack dynamic-programming engine
package knap_pkg;

   localparam int unsigned MaxCapacityDefault = 30;
   localparam int unsigned PriceMax           = 100;

   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned PriceWidth = 7;
   localparam int unsigned SizeWidth  = 8;
   localparam int unsigned EntryWidth = 12;
   localparam int unsigned TotalWidth = 20;

   localparam logic [EntryWidth-1:0] EntryMax = '1;
   localparam logic [TotalWidth-1:0] TotalMax = '1;

   // command codes
   typedef enum logic [CmdWidth-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // engine sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SWEEP = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_QUERY = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [EntryWidth-1:0] best_value;
      logic [TotalWidth-1:0] running_total;
      logic                  rejected;
   } result_type;

endpackage

>>> sv/knap_ifs.sv
// valid/ready channel interfaces for requests and responses

interface knap_req_if;
   logic                                valid;
   logic                                ready;
   logic [knap_pkg::CmdWidth-1:0]       command;
   logic [knap_pkg::PriceWidth-1:0]     item_price;
   logic [knap_pkg::SizeWidth-1:0]      item_weight;
   logic [knap_pkg::SizeWidth-1:0]      carry_capacity;

   modport source (output valid, command, item_price, item_weight, carry_capacity,
                   input ready);
   modport sink   (input valid, command, item_price, item_weight, carry_capacity,
                   output ready);
endinterface

interface knap_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [knap_pkg::EntryWidth-1:0]     best_value;
   logic [knap_pkg::TotalWidth-1:0]     running_total;
   logic                                rejected;

   modport source (output valid, best_value, running_total, rejected, input ready);
   modport sink   (input valid, best_value, running_total, rejected, output ready);
endinterface

>>> sv/knap_ram.sv
// generic synchronous ram, one write port and two registered read ports
module knap_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> sv/knapsack_dp_engine.sv
// knapsack engine top level: sequencer, best-value table and result register
//
//   channel   direction  payload
//   req_ch    in         command, item_price, item_weight, carry_capacity
//   rsp_ch    out        best_value, running_total, rejected
//
// an add walks the table from MAX_CAPACITY down to the weight, one entry per
// cycle through the table's single write port, then drains its last write
// a query adds its entry to the total; a clear or a refused command goes to done
// one command is in work at a time; the response register lets the next
// command start while a response waits on a stalled rsp_ch
// synchronous reset clears the table's valid bits and the total; no sweep
module knapsack_dp_engine #(
   parameter int unsigned MAX_CAPACITY = knap_pkg::MaxCapacityDefault
) (
   input logic        clock,
   input logic        reset,
   knap_req_if.sink   req_ch,
   knap_rsp_if.source rsp_ch
);

   localparam int unsigned Depth     = MAX_CAPACITY + 1;
   localparam int unsigned AddrWidth = $clog2(Depth);
   localparam int unsigned EW        = knap_pkg::EntryWidth;
   localparam int unsigned TW        = knap_pkg::TotalWidth;
   localparam int unsigned SW        = knap_pkg::SizeWidth;
   localparam logic [AddrWidth-1:0] MaxAddr = AddrWidth'(MAX_CAPACITY);
   localparam logic [SW-1:0]        MaxSize = SW'(MAX_CAPACITY);

   typedef logic [AddrWidth-1:0] addr_type;

   function automatic addr_type clamp_size(input logic [SW-1:0] v);
      addr_type r;
      if (v > MaxSize) r = MaxAddr;
      else             r = v[AddrWidth-1:0];
      return r;
   endfunction

   knap_pkg::state_type  state_ff, state_in;
   addr_type             j_ff, j_in;
   addr_type             w_ff, w_in;
   logic [knap_pkg::PriceWidth-1:0] price_ff, price_in;
   logic [TW-1:0]        total_ff, total_in;
   knap_pkg::result_type res_ff, res_in;
   knap_pkg::result_type out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   logic [Depth-1:0]     valid_ff, valid_in;
   logic                 s1_valid_ff, s1_valid_in;
   addr_type             s1_addr_ff, s1_addr_in;
   logic                 rda_valid_ff, rda_valid_in;
   logic                 rdb_valid_ff, rdb_valid_in;

   addr_type             rd_addr_a, rd_addr_b;
   logic [EW-1:0]        rd_data_a, rd_data_b;
   logic                 wr_en;
   logic [EW-1:0]        wr_data;

   logic                 req_fire;
   logic [EW-1:0]        old_val, low_val, cand_sat, query_val;
   logic [EW:0]          cand;
   logic [TW:0]          sum;

   assign req_ch.ready = (state_ff == knap_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // best-value table
   knap_ram #(
      .WIDTH (EW),
      .DEPTH (Depth)
   ) u_knap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (s1_addr_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // read addresses: query entry at accept, else the sweep pair
   always_comb begin
      if (state_ff == knap_pkg::ST_IDLE) rd_addr_a = clamp_size(req_ch.carry_capacity);
      else                               rd_addr_a = j_ff;
      rd_addr_b    = j_ff - w_ff;
      rda_valid_in = valid_ff[rd_addr_a];
      rdb_valid_in = valid_ff[rd_addr_b];
   end

   // update stage: max of kept entry and entry below plus price
   always_comb begin
      old_val   = rda_valid_ff ? rd_data_a : '0;
      low_val   = rdb_valid_ff ? rd_data_b : '0;
      query_val = old_val;
      cand      = {1'b0, low_val} + (EW+1)'(price_ff);
      cand_sat  = cand[EW] ? knap_pkg::EntryMax : cand[EW-1:0];
      wr_data   = (cand_sat > old_val) ? cand_sat : old_val;
      wr_en     = s1_valid_ff;
      sum       = {1'b0, total_ff} + (TW+1)'(query_val);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      price_in     = price_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      valid_in     = valid_ff;
      s1_valid_in  = 1'b0;
      s1_addr_in   = j_ff;

      // response register drains on transfer
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         knap_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_in.best_value    = '0;
               res_in.running_total = total_ff;
               res_in.rejected      = 1'b0;
               state_in             = knap_pkg::ST_DONE;
               case (req_ch.command)
                  knap_pkg::CMD_CLEAR: begin
                     valid_in             = '0;
                     total_in             = '0;
                     res_in.running_total = '0;
                  end
                  knap_pkg::CMD_ADD: begin
                     if (req_ch.item_price == '0 ||
                         32'(req_ch.item_price) > knap_pkg::PriceMax ||
                         req_ch.item_weight == '0) begin
                        res_in.rejected = 1'b1;
                     end else begin
                        j_in     = MaxAddr;
                        w_in     = clamp_size(req_ch.item_weight);
                        price_in = req_ch.item_price;
                        state_in = knap_pkg::ST_SWEEP;
                     end
                  end
                  knap_pkg::CMD_QUERY: begin
                     if (req_ch.carry_capacity == '0) res_in.rejected = 1'b1;
                     else                             state_in = knap_pkg::ST_QUERY;
                  end
                  default: begin
                     res_in.rejected = 1'b1;
                  end
               endcase
            end
         end
         knap_pkg::ST_SWEEP: begin
            s1_valid_in = 1'b1;
            s1_addr_in  = j_ff;
            if (j_ff == w_ff) state_in = knap_pkg::ST_DRAIN;
            else              j_in     = j_ff - 1'b1;
         end
         knap_pkg::ST_DRAIN: begin
            // last write of the sweep lands this cycle
            state_in = knap_pkg::ST_DONE;
         end
         knap_pkg::ST_QUERY: begin
            total_in             = sum[TW] ? knap_pkg::TotalMax : sum[TW-1:0];
            res_in.best_value    = query_val;
            res_in.running_total = total_in;
            res_in.rejected      = 1'b0;
            state_in             = knap_pkg::ST_DONE;
         end
         knap_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = knap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = knap_pkg::ST_IDLE;
         end
      endcase

      // written entries become valid
      if (s1_valid_ff) begin
         valid_in[s1_addr_ff] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= knap_pkg::ST_IDLE;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      w_ff         <= w_in;
      price_ff     <= price_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
      s1_addr_ff   <= s1_addr_in;
      rda_valid_ff <= rda_valid_in;
      rdb_valid_ff <= rdb_valid_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.best_value    = out_ff.best_value;
   assign rsp_ch.running_total = out_ff.running_total;
   assign rsp_ch.rejected      = out_ff.rejected;

endmodule

>>> sv/knap_checker.sv
// port-level assertions for the knapsack engine, bound to the top level
module knap_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [knap_pkg::EntryWidth-1:0]   rsp_best_value,
   input logic [knap_pkg::TotalWidth-1:0]   rsp_running_total,
   input logic                              rsp_rejected
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_value) &&
      $stable(rsp_running_total) && $stable(rsp_rejected))
      else $error("response changed while stalled");

   // a refused command answers no value
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_best_value == '0)
      else $error("refused command carries a value");

   // one command in work at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while engine busy");

   // a query answer is already counted in the total
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_best_value != '0 |->
      rsp_running_total >= knap_pkg::TotalWidth'(rsp_best_value))
      else $error("running total below answered value");

endmodule

bind knapsack_dp_engine knap_checker u_knap_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_best_value    (rsp_ch.best_value),
   .rsp_running_total (rsp_ch.running_total),
   .rsp_rejected      (rsp_ch.rejected)
);

>>> tb/tb_knapsack_dp_engine.sv
// self-checking testbench for the knapsack dynamic-programming engine
module tb_knapsack_dp_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Cap = knap_pkg::MaxCapacityDefault;
   localparam logic [knap_pkg::CmdWidth-1:0] CmdUnused = 2'd3;
   localparam int unsigned SettleCycles = 60;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_SPARSE
   } stall_mode_type;

   // mirror of the best-value table and total, with the answers still owed
   class knapsack_mirror;
      int unsigned          best_by_capacity[Cap+1];
      int unsigned          total;
      knap_pkg::result_type pending_answers[$];
      int unsigned          errors;

      function new();
         foreach (best_by_capacity[j]) best_by_capacity[j] = 0;
         total  = 0;
         errors = 0;
      endfunction

      function void note_command(input logic [knap_pkg::CmdWidth-1:0]   command,
                                 input logic [knap_pkg::PriceWidth-1:0] price,
                                 input logic [knap_pkg::SizeWidth-1:0]  weight,
                                 input logic [knap_pkg::SizeWidth-1:0]  capacity);
         knap_pkg::result_type answer;
         int unsigned w;
         int unsigned c;
         int unsigned cand;
         int          j;
         answer = '0;
         case (command)
            knap_pkg::CMD_CLEAR: begin
               foreach (best_by_capacity[i]) best_by_capacity[i] = 0;
               total = 0;
            end
            knap_pkg::CMD_ADD: begin
               if (price == 0 || price > knap_pkg::PriceMax || weight == 0) begin
                  answer.rejected = 1'b1;
               end else begin
                  w = (weight > Cap) ? Cap : weight;
                  // walk downwards so each item is folded in at most once
                  for (j = Cap; j >= int'(w); j--) begin
                     cand = best_by_capacity[j - w] + price;
                     if (cand > knap_pkg::EntryMax) cand = 32'(knap_pkg::EntryMax);
                     if (cand > best_by_capacity[j]) best_by_capacity[j] = cand;
                  end
               end
            end
            knap_pkg::CMD_QUERY: begin
               if (capacity == 0) begin
                  answer.rejected = 1'b1;
               end else begin
                  c = (capacity > Cap) ? Cap : capacity;
                  answer.best_value = knap_pkg::EntryWidth'(best_by_capacity[c]);
                  // total saturates rather than wrapping
                  if (total + best_by_capacity[c] > knap_pkg::TotalMax)
                     total = 32'(knap_pkg::TotalMax);
                  else total = total + best_by_capacity[c];
               end
            end
            default: begin
               answer.rejected = 1'b1;
            end
         endcase
         answer.running_total = knap_pkg::TotalWidth'(total);
         pending_answers.push_back(answer);
      endfunction

      function void check_answer(input logic [knap_pkg::EntryWidth-1:0] best_value,
                                 input logic [knap_pkg::TotalWidth-1:0] running_total,
                                 input logic                            rejected);
         knap_pkg::result_type want;
         if (pending_answers.size() == 0) begin
            $error("response with no command outstanding: best_value %0d running_total %0d",
                   best_value, running_total);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (best_value !== want.best_value) begin
               $error("best_value: expected %0d, got %0d", want.best_value, best_value);
               errors++;
            end
            if (running_total !== want.running_total) begin
               $error("running_total: expected %0d, got %0d",
                      want.running_total, running_total);
               errors++;
            end
            if (rejected !== want.rejected) begin
               $error("rejected: expected %0d, got %0d", want.rejected, rejected);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   knap_req_if req_ch ();
   knap_rsp_if rsp_ch ();

   knapsack_mirror tracker = new();
   int unsigned    burst_left;

   knapsack_dp_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch both channels for transfers
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         tracker.note_command(req_ch.command, req_ch.item_price, req_ch.item_weight,
                              req_ch.carry_capacity);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_answer(rsp_ch.best_value, rsp_ch.running_total, rsp_ch.rejected);
   end

   // response back-pressure: modes of random span
   initial begin : rsp_backpressure
      stall_mode_type mode;
      int unsigned    span;
      int unsigned    phase;
      phase = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 200);
         repeat (span) begin
            @(posedge clock);
            phase++;
            case (mode)
               STALL_NONE:     rsp_ch.ready <= 1'b1;
               STALL_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
               STALL_PERIODIC: rsp_ch.ready <= (phase % 4 == 0);
               default:        rsp_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   // one request transfer, then a gap when the burst runs out
   task automatic send_command(input logic [knap_pkg::CmdWidth-1:0]   command,
                               input logic [knap_pkg::PriceWidth-1:0] price,
                               input logic [knap_pkg::SizeWidth-1:0]  weight,
                               input logic [knap_pkg::SizeWidth-1:0]  capacity);
      int unsigned gap;
      req_ch.valid          <= 1'b1;
      req_ch.command        <= command;
      req_ch.item_price     <= price;
      req_ch.item_weight    <= weight;
      req_ch.carry_capacity <= capacity;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // random field values of the exact field widths
   function automatic logic [knap_pkg::CmdWidth-1:0] any_command();
      return knap_pkg::CmdWidth'($urandom);
   endfunction

   function automatic logic [knap_pkg::PriceWidth-1:0] any_price();
      return knap_pkg::PriceWidth'($urandom);
   endfunction

   function automatic logic [knap_pkg::SizeWidth-1:0] any_size();
      return knap_pkg::SizeWidth'($urandom);
   endfunction

   function automatic logic [knap_pkg::SizeWidth-1:0] pick_weight();
      if ($urandom_range(0, 7) == 0) return knap_pkg::SizeWidth'($urandom_range(Cap + 1, 255));
      return knap_pkg::SizeWidth'($urandom_range(1, Cap));
   endfunction

   function automatic logic [knap_pkg::SizeWidth-1:0] pick_capacity();
      if ($urandom_range(0, 11) == 0) return '0;
      if ($urandom_range(0, 7) == 0) return knap_pkg::SizeWidth'($urandom_range(Cap + 1, 255));
      return knap_pkg::SizeWidth'($urandom_range(1, Cap));
   endfunction

   // random episodes: optional clear, then adds, queries and some refused commands
   task automatic run_mixed_episodes(input int unsigned budget);
      int unsigned sent;
      int unsigned n;
      int unsigned k;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 2) == 0) begin
            send_command(knap_pkg::CMD_CLEAR, any_price(), any_size(), any_size());
            sent++;
         end
         n = $urandom_range(1, 14);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
               0: begin
                  // refused: bad price, zero weight, unused command or anything
                  case ($urandom_range(0, 3))
                     0: send_command(knap_pkg::CMD_ADD, $urandom_range(0, 1) ? 7'd0
                                     : 7'($urandom_range(knap_pkg::PriceMax + 1, 127)),
                                     any_size(), any_size());
                     1: send_command(knap_pkg::CMD_ADD, any_price(), '0, any_size());
                     2: send_command(CmdUnused, any_price(), any_size(), any_size());
                     default: send_command(any_command(), any_price(), any_size(),
                                           any_size());
                  endcase
               end
               1, 2, 3: begin
                  send_command(knap_pkg::CMD_QUERY, any_price(), any_size(),
                               pick_capacity());
                  sent++;
               end
               default: begin
                  send_command(knap_pkg::CMD_ADD,
                               knap_pkg::PriceWidth'($urandom_range(1, knap_pkg::PriceMax)),
                               pick_weight(), any_size());
                  sent++;
               end
            endcase
         end
      end
   endtask

   // stimulus
   initial begin : stimulus
      int unsigned k;
      req_ch.valid          <= 1'b0;
      req_ch.command        <= knap_pkg::CMD_CLEAR;
      req_ch.item_price     <= '0;
      req_ch.item_weight    <= '0;
      req_ch.carry_capacity <= '0;
      burst_left = $urandom_range(1, 24);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, field extremes, clamping and refusals
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd5);
      send_command(knap_pkg::CMD_ADD, 7'd100, 8'd1, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd1, 8'd30, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd0, 8'd5, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd101, 8'd5, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd127, 8'd255, 8'd255);
      send_command(knap_pkg::CMD_ADD, 7'd50, 8'd0, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd60, 8'd255, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd7, 8'd31, 8'd0);
      send_command(knap_pkg::CMD_ADD, 7'd40, 8'd10, 8'd0);
      send_command(knap_pkg::CMD_QUERY, 7'd127, 8'd255, 8'd0);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd1);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd30);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd255);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd31);
      send_command(CmdUnused, any_price(), any_size(), any_size());
      send_command(CmdUnused, '1, '1, '1);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd11);
      send_command(knap_pkg::CMD_CLEAR, '1, '1, '1);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd30);
      send_command(knap_pkg::CMD_ADD, 7'd100, 8'd30, 8'd0);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd29);
      send_command(knap_pkg::CMD_QUERY, 7'd0, 8'd0, 8'd30);

      run_mixed_episodes(450);

      // fill the table with Cap items of the top price and weight 1, then query until the total saturates
      send_command(knap_pkg::CMD_CLEAR, any_price(), any_size(), any_size());
      for (k = 0; k < Cap; k++)
         send_command(knap_pkg::CMD_ADD, knap_pkg::PriceWidth'(knap_pkg::PriceMax), 8'd1,
                      any_size());
      for (k = 0; k < 360; k++)
         send_command(knap_pkg::CMD_QUERY, any_price(), any_size(),
                      knap_pkg::SizeWidth'($urandom_range(Cap, 255)));

      req_ch.valid <= 1'b0;
      while (tracker.pending_answers.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending_answers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
